[rtl/utf8_bmp_char_decoder_core_macros.svh]
// Assertion helpers shared by the decoder modules.
`ifndef UTF8_BMP_CHAR_DECODER_CORE_MACROS_SVH
`define UTF8_BMP_CHAR_DECODER_CORE_MACROS_SVH

// cond must never hold outside reset
`define U8BD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// ante at an edge implies cons at the same edge
`define U8BD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante at an edge implies cons at the next edge
`define U8BD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/utf8bd_pkg.sv]
`default_nettype none

package utf8bd_pkg;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam int AccumW = 21;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_BAD
    } t_byte_class;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_BAD_CONT = 2'd2,
        ST_NON_BMP  = 2'd3
    } t_status;

    typedef struct packed {
        t_byte_class cls;
        logic [7:0]  data;
    } t_cls_item;

    typedef struct packed {
        logic [15:0] code_unit;
        t_status     status;
    } t_result;

endpackage

`default_nettype wire

[rtl/utf8_bmp_char_decoder_core.sv]
// UTF-8 to UTF-16 decoder for the Basic Multilingual Plane. Bytes go in through a queue-style
// port (push/full) and decoded code units come out through another (empty/pop); each result
// carries a status: 0 ok, 1 bad lead byte, 2 bad continuation byte, 3 code point above 0xFFFF.
// Only completed characters and errors produce a result; the offending byte of an error is
// consumed. Overlong forms are decoded as they stand. One byte is taken per clock while full is
// low; each accepted byte is classified and written into a four-entry queue, and the decode
// stage writes each result into a two-entry result buffer that feeds the result port. Full rises
// only when the result side has stalled long enough to fill both buffers.
`default_nettype none

module utf8_bmp_char_decoder_core
    import utf8bd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      o_code_unit,
    output logic [1:0]       o_status
);

    t_cls_item front_item;
    t_cls_item q_item;
    logic      q_empty;
    logic      q_rd;

    utf8bd_front u_front (
        .i_data_byte (i_data_byte),
        .o_item      (front_item)
    );

    utf8bd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_item (front_item),
        .o_full    (full),
        .i_rd      (q_rd),
        .o_rd_item (q_item),
        .o_empty   (q_empty)
    );

    utf8bd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_item_empty (q_empty),
        .o_item_rd    (q_rd),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_code_unit  (o_code_unit),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire

[rtl/utf8bd_front.sv]
`default_nettype none

module utf8bd_front
    import utf8bd_pkg::*;
(
    input  wire logic [7:0] i_data_byte,
    output t_cls_item       o_item
);

    t_byte_class cls;

    always_comb begin
        if (i_data_byte[7] == 1'b0) begin
            cls = CLS_ASCII;
        end else if (i_data_byte[7:6] == 2'b10) begin
            cls = CLS_CONT;
        end else if (i_data_byte[7:5] == 3'b110) begin
            cls = CLS_LEAD2;
        end else if (i_data_byte[7:4] == 4'b1110) begin
            cls = CLS_LEAD3;
        end else if (i_data_byte[7:3] == 5'b11110) begin
            cls = CLS_LEAD4;
        end else begin
            cls = CLS_BAD;
        end
    end

    assign o_item.cls  = cls;
    assign o_item.data = i_data_byte;

endmodule

`default_nettype wire

[rtl/utf8bd_queue.sv]
`default_nettype none
`include "utf8_bmp_char_decoder_core_macros.svh"

module utf8bd_queue
    import utf8bd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_wr,
    input  wire t_cls_item i_wr_item,
    output logic           o_full,
    input  wire logic      i_rd,
    output t_cls_item      o_rd_item,
    output logic           o_empty
);

    t_cls_item              r_mem [QDepth];
    logic [QPtrW-1:0]       r_wr_ptr, n_wr_ptr;
    logic [QPtrW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [QCntW-1:0]       r_cnt, n_cnt;
    logic                   wr_en, rd_en;

    assign o_full    = (r_cnt == QCntW'(QDepth));
    assign o_empty   = (r_cnt == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_item = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = wr_en ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = rd_en ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt + QCntW'(wr_en) - QCntW'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    `U8BD_ASSERT_NEVER(a_q_cnt_range, r_cnt > QCntW'(QDepth), "queue count overrun")
    `U8BD_ASSERT_IMPLY(a_q_ptr_track, o_empty || o_full, r_wr_ptr == r_rd_ptr, "pointer mismatch")

endmodule

`default_nettype wire

[rtl/utf8bd_back.sv]
`default_nettype none
`include "utf8_bmp_char_decoder_core_macros.svh"

module utf8bd_back
    import utf8bd_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cls_item    i_item,
    input  wire logic         i_item_empty,
    output logic              o_item_rd,
    output logic              o_empty,
    input  wire logic         i_pop,
    output logic [15:0]       o_code_unit,
    output logic [1:0]        o_status
);

    logic [1:0]        r_pending, n_pending;
    logic [AccumW-1:0] r_accum, n_accum;
    t_result           r_res [2];
    logic              r_res_wr, r_res_rd;
    logic [1:0]        r_res_cnt, n_res_cnt;

    logic              take, pop_en, emit;
    logic              lead4_take;
    t_result           res;
    logic [AccumW-1:0] acc_shift;

    assign pop_en     = i_pop && !o_empty;
    assign take       = !i_item_empty && (r_res_cnt != 2'd2);
    assign o_item_rd  = take;
    assign acc_shift  = {r_accum[AccumW-7:0], i_item.data[5:0]};
    assign lead4_take = take && r_pending == 2'd0 && i_item.cls == CLS_LEAD4;

    always_comb begin
        n_pending     = r_pending;
        n_accum       = r_accum;
        emit          = 1'b0;
        res.code_unit = '0;
        res.status    = ST_OK;
        if (take) begin
            if (r_pending == 2'd0) begin
                unique case (i_item.cls)
                    CLS_ASCII: begin
                        emit          = 1'b1;
                        res.code_unit = {8'h00, i_item.data};
                    end
                    CLS_LEAD2: begin
                        n_accum   = AccumW'(i_item.data[4:0]);
                        n_pending = 2'd1;
                    end
                    CLS_LEAD3: begin
                        n_accum   = AccumW'(i_item.data[3:0]);
                        n_pending = 2'd2;
                    end
                    CLS_LEAD4: begin
                        n_accum   = AccumW'(i_item.data[2:0]);
                        n_pending = 2'd3;
                    end
                    default: begin
                        n_accum    = '0;
                        emit       = 1'b1;
                        res.status = ST_BAD_LEAD;
                    end
                endcase
            end else if (i_item.cls != CLS_CONT) begin
                n_pending  = 2'd0;
                n_accum    = '0;
                emit       = 1'b1;
                res.status = ST_BAD_CONT;
            end else if (r_pending != 2'd1) begin
                n_accum   = acc_shift;
                n_pending = r_pending - 2'd1;
            end else begin
                n_accum   = '0;
                n_pending = 2'd0;
                emit      = 1'b1;
                if (|acc_shift[AccumW-1:16]) begin
                    res.status = ST_NON_BMP;
                end else begin
                    res.code_unit = acc_shift[15:0];
                end
            end
        end
        n_res_cnt = r_res_cnt + 2'(emit) - 2'(pop_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_accum   <= '0;
            r_res_wr  <= 1'b0;
            r_res_rd  <= 1'b0;
            r_res_cnt <= '0;
        end else begin
            r_pending <= n_pending;
            r_accum   <= n_accum;
            r_res_cnt <= n_res_cnt;
            if (emit) begin
                r_res_wr <= ~r_res_wr;
            end
            if (pop_en) begin
                r_res_rd <= ~r_res_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res[r_res_wr] <= res;
        end
    end

    assign o_empty     = (r_res_cnt == 2'd0);
    assign o_code_unit = r_res[r_res_rd].code_unit;
    assign o_status    = r_res[r_res_rd].status;

    `U8BD_ASSERT_NEVER(a_res_cnt_range, r_res_cnt == 2'd3, "result buffer overrun")
    `U8BD_ASSERT_IMPLY(a_idle_accum_clear, r_pending == 2'd0, r_accum == '0, "stale accumulator")
    `U8BD_ASSERT_NEXT(a_lead_sets_pending, lead4_take, r_pending == 2'd3, "four-byte lead lost")

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import utf8bd_pkg::*;

    localparam int DrainMark = -1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [15:0] o_code_unit;
    logic [1:0]  o_status;

    utf8_bmp_char_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .empty       (empty),
        .pop         (pop),
        .o_code_unit (o_code_unit),
        .o_status    (o_status)
    );

    always #6 i_clk = ~i_clk;

    int          pending_bytes[$];
    t_result     expected_units[$];
    logic [1:0]  dec_pending = '0;
    logic [20:0] dec_accum = '0;
    int          mismatches = 0;
    logic        byte_taken = 1'b0;
    int          send_gap = 0;
    int          send_calm = 0;
    int          hold_left = 0;
    int          pop_calm = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int idle_len(inout int calm_left);
        int pick;
        pick = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (pick < 3) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // returns 1 when the byte completes a character or raises an error
    function automatic bit decode_byte(input logic [7:0] b, output t_result r);
        logic [20:0] cp;
        r.code_unit = '0;
        r.status    = ST_OK;
        if (dec_pending == 2'd0) begin
            if (b[7] == 1'b0) begin
                r.code_unit = {8'h00, b};
                return 1'b1;
            end else if (b[7:5] == 3'b110) begin
                dec_accum   = {16'h0000, b[4:0]};
                dec_pending = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                dec_accum   = {17'h00000, b[3:0]};
                dec_pending = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                dec_accum   = {18'h00000, b[2:0]};
                dec_pending = 2'd3;
            end else begin
                dec_accum = '0;
                r.status  = ST_BAD_LEAD;
                return 1'b1;
            end
            return 1'b0;
        end
        if (b[7:6] != 2'b10) begin
            dec_pending = 2'd0;
            dec_accum   = '0;
            r.status    = ST_BAD_CONT;
            return 1'b1;
        end
        dec_accum   = {dec_accum[14:0], b[5:0]};
        dec_pending = dec_pending - 2'd1;
        if (dec_pending != 2'd0) return 1'b0;
        cp        = dec_accum;
        dec_accum = '0;
        if (cp > 21'h00FFFF) r.status = ST_NON_BMP;
        else r.code_unit = cp[15:0];
        return 1'b1;
    endfunction

    task automatic queue_bytes(input int vals[]);
        foreach (vals[i]) pending_bytes.push_back(vals[i]);
    endtask

    // well-formed characters with random payload, broken sequences and noise
    task automatic queue_random(input int target);
        int n;
        int kind;
        int len;
        int conts;
        int top;
        n = 0;
        while (n < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                pending_bytes.push_back($urandom_range(0, 255));
                n++;
            end else begin
                len = $urandom_range(1, 4);
                case (len)
                    1: pending_bytes.push_back($urandom_range(0, 127));
                    2: pending_bytes.push_back(8'hC0 | $urandom_range(0, 31));
                    3: pending_bytes.push_back(8'hE0 | $urandom_range(0, 15));
                    default: pending_bytes.push_back(8'hF0 | $urandom_range(0, 7));
                endcase
                n++;
                conts = len - 1;
                if (kind < 30 && len > 1) conts = $urandom_range(0, len - 2);
                repeat (conts) begin
                    pending_bytes.push_back(8'h80 | $urandom_range(0, 63));
                    n++;
                end
                if (kind < 30 && len > 1) begin
                    top = $urandom_range(0, 2);
                    if (top == 2) top = 3;
                    pending_bytes.push_back((top << 6) | $urandom_range(0, 63));
                    n++;
                end
            end
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        logic       next_push;
        logic [7:0] next_data;
        int         item;
        next_push = push;
        next_data = i_data_byte;
        if (i_rst_n && (!push || byte_taken)) begin
            next_push = 1'b0;
            next_data = $urandom_range(0, 255);
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_bytes.size() != 0) begin
                if (pending_bytes[0] == DrainMark) begin
                    if (expected_units.size() == 0) void'(pending_bytes.pop_front());
                end else begin
                    item      = pending_bytes.pop_front();
                    next_push = 1'b1;
                    next_data = item[7:0];
                    send_gap  = idle_len(send_calm);
                end
            end
        end
        push        <= next_push;
        i_data_byte <= next_data;
    end

    // result side stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold_left = idle_len(pop_calm);
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            byte_taken <= 1'b0;
        end else begin
            byte_taken <= push && !full;
            if (pop && !empty) begin
                if (expected_units.size() == 0) begin
                    report_mismatch($sformatf("unexpected result unit=%h status=%0d",
                                              o_code_unit, o_status));
                end else begin
                    want = expected_units.pop_front();
                    if (o_code_unit != want.code_unit)
                        report_mismatch($sformatf("code_unit %h, want %h",
                                                  o_code_unit, want.code_unit));
                    if (o_status != want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  o_status, want.status));
                end
            end
            if (push && !full) begin
                if (decode_byte(i_data_byte, fresh)) expected_units.push_back(fresh);
            end
        end
    end

    initial begin
        // ASCII extremes, bad leads, overlong and maximal forms, beyond-BMP, broken sequences
        queue_bytes('{8'h00, 8'h7F, 8'h80, 8'hF8, 8'hFF,
                      8'hC0, 8'h80, 8'hDF, 8'hBF,
                      8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                      8'hC3, 8'h41, 8'hE2, 8'h82, 8'hFF});
        pending_bytes.push_back(DrainMark);
        queue_random(325);
        pending_bytes.push_back(DrainMark);
        queue_random(325);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || push) @(posedge i_clk);
        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && expected_units.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/utf8bd_pkg.sv
rtl/utf8bd_front.sv
rtl/utf8bd_queue.sv
rtl/utf8bd_back.sv
rtl/utf8_bmp_char_decoder_core.sv
tb/testbench.sv
